[hdl/multi_timer_pool_top_assert.svh]
// ---------------------------------------------------------------------------
// multi_timer_pool_top_assert.svh
// assertion macros shared by the timer pool modules
// ---------------------------------------------------------------------------
`ifndef MULTI_TIMER_POOL_TOP_ASSERT_SVH
`define MULTI_TIMER_POOL_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MTP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define MTP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MTP_ASSERT_IMP(lbl, ante, cons, msg)
`define MTP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[hdl/mtp_pkg.sv]
// ---------------------------------------------------------------------------
// mtp_pkg
// result codes, limits and controller/datapath interface types
// ---------------------------------------------------------------------------
package mtp_pkg;

  // request and result field widths
  localparam int DUR_W     = 32;
  localparam int KIND_W    = 2;
  localparam int OUT_IDX_W = 3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_STARTED      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BAD_DURATION = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ALL_BUSY     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_EXPIRED      = 2'd3;

  // expiry results reported per tick
  localparam int MAX_RESULTS = 8;
  localparam int REP_W       = $clog2(MAX_RESULTS + 1);

  // controller to datapath commands
  typedef struct packed {
    logic load;        // latch request, rewind scan
    logic start_step;  // check one channel for a start request
    logic tick_read;   // fetch one channel's countdown for a tick
    logic emit_bad;    // report bad duration
    logic flush;       // report the held expiry as the last one
  } mtp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic dur_zero;    // incoming duration is zero
    logic sel_free;    // channel under the scan pointer is free
    logic idx_last;    // scan pointer is on the last channel
  } mtp_status_t;

endpackage

[hdl/mtp_ram.sv]
// ---------------------------------------------------------------------------
// mtp_ram
// generic one-write one-read ram with registered read data
// ---------------------------------------------------------------------------
module mtp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/mtp_ctrl.sv]
// ---------------------------------------------------------------------------
// mtp_ctrl
// sequencer for start requests and tick scans of the timer pool
// ---------------------------------------------------------------------------
`include "multi_timer_pool_top_assert.svh"
module mtp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                req_type,
  input  mtp_pkg::mtp_status_t st,
  output mtp_pkg::mtp_cmd_t   cmd,
  output logic                busy
);
  import mtp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BAD   = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_TICK  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (!req_type) begin
            state_next = S_TICK;
          end else if (st.dur_zero) begin
            state_next = S_BAD;
          end else begin
            state_next = S_START;
          end
        end
      end
      S_BAD: begin
        cmd.emit_bad = 1'b1;
        state_next   = S_IDLE;
      end
      S_START: begin
        cmd.start_step = 1'b1;
        if (st.sel_free || st.idx_last) begin
          state_next = S_IDLE;
        end
      end
      S_TICK: begin
        cmd.tick_read = 1'b1;
        if (st.idx_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FLUSH;
      end
      S_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `MTP_ASSERT_NXT(a_zero_dur, accept && req_type && st.dur_zero, state == S_BAD, "zero duration not rejected")
  `MTP_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0(cmd), "more than one command at once")
  `MTP_ASSERT_NXT(a_tick_drain, (state == S_TICK) && st.idx_last, state == S_DRAIN, "tick scan overran")

endmodule

[hdl/mtp_datapath.sv]
// ---------------------------------------------------------------------------
// mtp_datapath
// channel state, countdown rams, shared decrementer and result register
// ---------------------------------------------------------------------------
`include "multi_timer_pool_top_assert.svh"
module mtp_datapath #(
  parameter int NUM_CHANNELS = 8,
  parameter int COUNT_BITS   = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mtp_pkg::mtp_cmd_t                    cmd,
  output mtp_pkg::mtp_status_t                 st,
  input  logic [mtp_pkg::DUR_W-1:0]            duration_ticks,
  input  logic                                 periodic,
  output logic                                 strobe,
  output logic [mtp_pkg::KIND_W-1:0]           result_kind,
  output logic [mtp_pkg::OUT_IDX_W-1:0]        channel_index,
  output logic                                 last
);
  import mtp_pkg::*;

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int EXT_W = (IDX_W > OUT_IDX_W) ? IDX_W : OUT_IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

  // scan and channel state
  logic [IDX_W-1:0]        idx;
  logic                    s1_valid;
  logic [IDX_W-1:0]        s1_idx;
  logic [NUM_CHANNELS-1:0] chan_busy;
  logic [NUM_CHANNELS-1:0] chan_repeat;
  logic [COUNT_BITS-1:0]   dur_reg;
  logic                    per_reg;
  logic                    pend_valid;
  logic [IDX_W-1:0]        pend_idx;
  logic [REP_W-1:0]        rep_cnt;

  // result register
  logic                    res_strobe;
  logic [KIND_W-1:0]       res_kind;
  logic [OUT_IDX_W-1:0]    res_idx;
  logic                    res_last;

  logic [COUNT_BITS-1:0]   dur_sat;
  logic [COUNT_BITS-1:0]   ticks_rdata;
  logic [COUNT_BITS-1:0]   reload_rdata;
  logic [COUNT_BITS-1:0]   t_dec;
  logic [COUNT_BITS-1:0]   t_next;
  logic                    claim;
  logic                    expire;
  logic                    report;
  logic                    ticks_we;
  logic [IDX_W-1:0]        ticks_waddr;
  logic [COUNT_BITS-1:0]   ticks_wdata;

  logic                    emit_valid;
  logic [KIND_W-1:0]       emit_kind;
  logic [IDX_W-1:0]        emit_idx;
  logic                    emit_last;
  logic [EXT_W-1:0]        emit_ext;

  // duration fitted to the counter width
  always_comb begin
    dur_sat = COUNT_BITS'(duration_ticks);
    if ((duration_ticks >> COUNT_BITS) != '0) begin
      dur_sat = '1;
    end
  end

  // status to the controller
  assign st.dur_zero = (duration_ticks == '0);
  assign st.sel_free = !chan_busy[idx];
  assign st.idx_last = (idx == LAST_IDX);

  // start claims the channel under the pointer when it is free
  assign claim = cmd.start_step && !chan_busy[idx];

  // shared decrementer on the fetched countdown
  always_comb begin
    t_dec = (ticks_rdata != '0) ? (ticks_rdata - COUNT_BITS'(1)) : '0;
    expire = s1_valid && chan_busy[s1_idx] && (t_dec == '0);
    report = expire && (rep_cnt < REP_W'(MAX_RESULTS));
    t_next = (expire && chan_repeat[s1_idx]) ? reload_rdata : t_dec;
  end

  // countdown write port
  always_comb begin
    ticks_we    = claim || (s1_valid && chan_busy[s1_idx]);
    ticks_waddr = claim ? idx : s1_idx;
    ticks_wdata = claim ? dur_reg : t_next;
  end

  mtp_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_CHANNELS)
  ) u_ticks_ram (
    .clk   (clk),
    .we    (ticks_we),
    .waddr (ticks_waddr),
    .wdata (ticks_wdata),
    .raddr (idx),
    .rdata (ticks_rdata)
  );

  mtp_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_CHANNELS)
  ) u_reload_ram (
    .clk   (clk),
    .we    (claim),
    .waddr (idx),
    .wdata (dur_reg),
    .raddr (idx),
    .rdata (reload_rdata)
  );

  // result selection
  always_comb begin
    emit_valid = 1'b0;
    emit_kind  = KIND_STARTED;
    emit_idx   = '0;
    emit_last  = 1'b1;
    if (cmd.emit_bad) begin
      emit_valid = 1'b1;
      emit_kind  = KIND_BAD_DURATION;
    end else if (claim) begin
      emit_valid = 1'b1;
      emit_kind  = KIND_STARTED;
      emit_idx   = idx;
    end else if (cmd.start_step && st.idx_last) begin
      emit_valid = 1'b1;
      emit_kind  = KIND_ALL_BUSY;
    end else if (report && pend_valid) begin
      emit_valid = 1'b1;
      emit_kind  = KIND_EXPIRED;
      emit_idx   = pend_idx;
      emit_last  = 1'b0;
    end else if (cmd.flush && pend_valid) begin
      emit_valid = 1'b1;
      emit_kind  = KIND_EXPIRED;
      emit_idx   = pend_idx;
    end
    emit_ext = EXT_W'(emit_idx);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      s1_valid    <= 1'b0;
      chan_busy   <= '0;
      chan_repeat <= '0;
      pend_valid  <= 1'b0;
      rep_cnt     <= '0;
      res_strobe  <= 1'b0;
    end else begin
      s1_valid   <= cmd.tick_read;
      res_strobe <= emit_valid;
      if (cmd.load) begin
        idx        <= '0;
        pend_valid <= 1'b0;
        rep_cnt    <= '0;
      end else if ((cmd.tick_read || (cmd.start_step && !claim)) && !st.idx_last) begin
        idx <= idx + IDX_W'(1);
      end
      if (claim) begin
        chan_busy[idx]   <= 1'b1;
        chan_repeat[idx] <= per_reg;
      end
      if (expire && !chan_repeat[s1_idx]) begin
        chan_busy[s1_idx]   <= 1'b0;
        chan_repeat[s1_idx] <= 1'b0;
      end
      if (report) begin
        pend_valid <= 1'b1;
        rep_cnt    <= rep_cnt + REP_W'(1);
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1_idx <= idx;
    if (cmd.load) begin
      dur_reg <= dur_sat;
      per_reg <= periodic;
    end
    if (report) begin
      pend_idx <= s1_idx;
    end
    if (emit_valid) begin
      res_kind <= emit_kind;
      res_idx  <= emit_ext[OUT_IDX_W-1:0];
      res_last <= emit_last;
    end
  end

  assign strobe        = res_strobe;
  assign result_kind   = res_kind;
  assign channel_index = res_idx;
  assign last          = res_last;

  `MTP_ASSERT_IMP(a_err_last, res_strobe && (res_kind != KIND_EXPIRED), res_last, "single result not marked last")
  `MTP_ASSERT_IMP(a_rep_cap, 1'b1, rep_cnt <= REP_W'(MAX_RESULTS), "expiry report count overflow")
  `MTP_ASSERT_NXT(a_flush_clr, cmd.flush, !pend_valid, "held expiry survived flush")

endmodule

[hdl/multi_timer_pool_top.sv]
// ---------------------------------------------------------------------------
// multi_timer_pool_top
// bank of one-shot and periodic countdown channels
// ---------------------------------------------------------------------------
// start request: one channel checked per cycle from index 0 until a free one is
//   claimed or the last one is checked, with busy high while the search runs; a
//   zero duration skips the search and answers with a bad-duration result
// tick: busy covers the scan, a drain state and a flush state, paced by one shared
//   decrementer and one countdown ram read per cycle; expiries leave at most one
//   per cycle in index order
// reset (rst, synchronous) frees every channel; the countdown rams are not cleared
module multi_timer_pool_top #(
  parameter int NUM_CHANNELS = 8,
  parameter int COUNT_BITS   = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type,
  input  logic [mtp_pkg::DUR_W-1:0]     duration_ticks,
  input  logic                          periodic,
  output logic                          strobe,
  output logic [mtp_pkg::KIND_W-1:0]    result_kind,
  output logic [mtp_pkg::OUT_IDX_W-1:0] channel_index,
  output logic                          last
);
  import mtp_pkg::*;

  mtp_cmd_t    cmd;
  mtp_status_t st;

  // request sequencer
  mtp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .st       (st),
    .cmd      (cmd),
    .busy     (busy)
  );

  // channel storage and result path
  mtp_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .duration_ticks (duration_ticks),
    .periodic       (periodic),
    .strobe         (strobe),
    .result_kind    (result_kind),
    .channel_index  (channel_index),
    .last           (last)
  );

endmodule

[tb/tb_multi_timer_pool_top.sv]
// ---------------------------------------------------------------------------
// tb_multi_timer_pool_top
// self-checking bench for the timer channel bank
// ---------------------------------------------------------------------------
// drives tick and start requests through the start/busy handshake, keeps a
// shadow copy of every channel's countdown to predict started, error and
// expiry results, and compares each strobed result field by field
// ---------------------------------------------------------------------------
module tb_multi_timer_pool_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mtp_pkg::*;

  localparam int   NUM_CH          = 8;
  localparam int   CNT_BITS        = 32;
  localparam int   CLK_PERIOD      = 20;
  localparam int   RESET_CYCLES    = 6;
  localparam int   WATCHDOG_LIMIT  = 2000;
  localparam int   SETTLE_CYCLES   = NUM_CH + 4;
  localparam int   PERIODIC_BUDGET = 4;
  localparam logic REQ_TICK        = 1'b0;
  localparam logic REQ_START       = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [OUT_IDX_W-1:0] idx;
    logic                 last;
  } timer_event_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 req_type;
  logic [DUR_W-1:0]     duration_ticks;
  logic                 periodic;
  logic                 strobe;
  logic [KIND_W-1:0]    result_kind;
  logic [OUT_IDX_W-1:0] channel_index;
  logic                 last;

  // shadow copy of the channel bank
  logic                chan_armed  [NUM_CH];
  logic                chan_repeat [NUM_CH];
  logic [CNT_BITS-1:0] chan_count  [NUM_CH];
  logic [CNT_BITS-1:0] chan_reload [NUM_CH];

  timer_event_t pending_events[$];
  int           error_count  = 0;
  int           stall_cycles = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  multi_timer_pool_top #(
    .NUM_CHANNELS(NUM_CH),
    .COUNT_BITS  (CNT_BITS)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .duration_ticks(duration_ticks),
    .periodic      (periodic),
    .strobe        (strobe),
    .result_kind   (result_kind),
    .channel_index (channel_index),
    .last          (last)
  );

  function automatic int free_channels();
    int n;
    n = 0;
    foreach (chan_armed[ch]) if (!chan_armed[ch]) n++;
    return n;
  endfunction

  function automatic int periodic_channels();
    int n;
    n = 0;
    foreach (chan_armed[ch]) if (chan_armed[ch] && chan_repeat[ch]) n++;
    return n;
  endfunction

  // update the shadow bank for one accepted request and queue its results
  task automatic advance_timer_bank(input logic rt, input logic [DUR_W-1:0] dur,
                                    input logic per);
    timer_event_t batch[$];
    int           free_ch;
    free_ch = -1;
    if (rt == REQ_START) begin
      // zero duration is rejected before the free-channel search
      if (dur == '0) begin
        batch.push_back('{kind: KIND_BAD_DURATION, idx: '0, last: 1'b1});
      end else begin
        for (int ch = NUM_CH - 1; ch >= 0; ch--) if (!chan_armed[ch]) free_ch = ch;
        if (free_ch < 0) begin
          batch.push_back('{kind: KIND_ALL_BUSY, idx: '0, last: 1'b1});
        end else begin
          chan_armed[free_ch]  = 1'b1;
          chan_repeat[free_ch] = per;
          chan_count[free_ch]  = dur;
          chan_reload[free_ch] = dur;
          batch.push_back('{kind: KIND_STARTED, idx: OUT_IDX_W'(free_ch), last: 1'b1});
        end
      end
    end else begin
      // tick: count down every armed channel, report expiries in index order
      for (int ch = 0; ch < NUM_CH; ch++) begin
        if (chan_armed[ch]) begin
          if (chan_count[ch] != '0) chan_count[ch] = chan_count[ch] - 1'b1;
          if (chan_count[ch] == '0) begin
            if (chan_repeat[ch]) begin
              chan_count[ch] = chan_reload[ch];
            end else begin
              chan_armed[ch]  = 1'b0;
              chan_repeat[ch] = 1'b0;
            end
            if (batch.size() < MAX_RESULTS)
              batch.push_back('{kind: KIND_EXPIRED, idx: OUT_IDX_W'(ch), last: 1'b0});
          end
        end
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    end
    foreach (batch[i]) pending_events.push_back(batch[i]);
  endtask

  // present one request at the falling edge and hold it until accepted
  task automatic send_request(input logic rt, input logic [DUR_W-1:0] dur,
                              input logic per);
    start          <= 1'b1;
    req_type       <= rt;
    duration_ticks <= dur;
    periodic       <= per;
    do @(posedge clk); while (busy);
    advance_timer_bank(rt, dur, per);
    @(negedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_events_drained();
    start <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    // a tick with no expiry may still be scanning
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---- directed tests ----

  task automatic test_idle_tick();
    // tick on an empty bank, ignored fields at their extremes
    send_request(REQ_TICK, 32'hFFFF_FFFF, 1'b1);
  endtask

  task automatic test_bad_duration();
    send_request(REQ_START, '0, 1'b0);
    send_request(REQ_START, '0, 1'b1);
  endtask

  task automatic test_fill_and_overflow();
    for (int ch = 0; ch < NUM_CH; ch++) send_request(REQ_START, 32'd2, 1'b0);
    // no free channel, then zero duration on a full bank
    send_request(REQ_START, 32'hFFFF_FFFF, 1'b1);
    send_request(REQ_START, '0, 1'b0);
    send_request(REQ_TICK, '0, 1'b0);
    // every channel expires on the same tick
    send_request(REQ_TICK, 32'hA5A5_5A5A, 1'b1);
  endtask

  task automatic test_periodic_reload();
    // interval of one fires on every tick
    send_request(REQ_START, 32'd1, 1'b1);
    send_request(REQ_START, 32'd3, 1'b1);
    send_request(REQ_START, 32'd1, 1'b0);
    repeat (4) send_request(REQ_TICK, 32'h0000_0001, 1'b0);
  endtask

  // ---- random traffic ----

  task automatic test_random_traffic(input int n_items, input bit with_gaps);
    int               sel;
    int               pick;
    logic [DUR_W-1:0] dur;
    logic             per;
    for (int k = 0; k < n_items; k++) begin
      sel = $urandom_range(0, 99);
      per = 1'($urandom_range(0, 1));
      if (sel < 52) begin
        send_request(REQ_TICK, $urandom(), per);
      end else if (sel < 57) begin
        send_request(REQ_START, '0, per);
      end else begin
        // full bank: any duration only hits the busy error, so use all bits
        if (free_channels() == 0) begin
          dur = $urandom();
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 80)      dur = $urandom_range(1, 8);
          else if (pick < 96) dur = $urandom_range(9, 40);
          else                dur = $urandom_range(41, 300);
          // periodic channels are never freed, keep some for one-shots
          if (periodic_channels() >= PERIODIC_BUDGET) per = 1'b0;
        end
        send_request(REQ_START, dur, per);
      end
      if (with_gaps && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 17));
    end
  endtask

  task automatic test_long_counts();
    // let one-shots run out so two channels are free
    while (free_channels() < 2) send_request(REQ_TICK, $urandom(), 1'b0);
    send_request(REQ_START, 32'hFFFF_FFFF, 1'b0);
    send_request(REQ_START, 32'h8000_0001, 1'b1);
    repeat (3) send_request(REQ_TICK, '0, 1'b0);
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    timer_event_t want;
    if (!rst && strobe) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d index %0d last %0d",
                 $time, result_kind, channel_index, last);
        error_count++;
      end else begin
        want = pending_events.pop_front();
        if (result_kind !== want.kind) begin
          $display("%0t: result_kind mismatch, expected %0d, actual %0d",
                   $time, want.kind, result_kind);
          error_count++;
        end
        if (channel_index !== want.idx) begin
          $display("%0t: channel_index mismatch, expected %0d, actual %0d",
                   $time, want.idx, channel_index);
          error_count++;
        end
        if (last !== want.last) begin
          $display("%0t: last mismatch, expected %0d, actual %0d",
                   $time, want.last, last);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no request accepted and no result
  always @(posedge clk) begin
    if ((start && !busy) || strobe) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    req_type       = REQ_TICK;
    duration_ticks = '0;
    periodic       = 1'b0;
    foreach (chan_armed[ch]) begin
      chan_armed[ch]  = 1'b0;
      chan_repeat[ch] = 1'b0;
      chan_count[ch]  = '0;
      chan_reload[ch] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_tick();
    test_bad_duration();
    test_fill_and_overflow();
    test_periodic_reload();
    test_random_traffic(200, 1'b1);
    // hold the sender until every result is out
    wait_events_drained();
    test_random_traffic(190, 1'b1);
    test_random_traffic(60, 1'b0);
    test_long_counts();

    wait_events_drained();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/mtp_pkg.sv
hdl/mtp_ram.sv
hdl/mtp_ctrl.sv
hdl/mtp_datapath.sv
hdl/multi_timer_pool_top.sv
tb/tb_multi_timer_pool_top.sv
